FILE: sv/sqlss_pkg.sv
package sqlss_pkg;

    typedef enum logic [2:0] {
        ROLE_CODE   = 3'd0,
        ROLE_SEP    = 3'd1,
        ROLE_LINE   = 3'd2,
        ROLE_BLOCK  = 3'd3,
        ROLE_SINGLE = 3'd4,
        ROLE_DOUBLE = 3'd5
    } t_role;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    typedef struct packed {
        logic [7:0] data;
        t_role      role;
        logic       fin;
    } t_result;

    // up to two results enter the queue per input transaction
    typedef struct packed {
        logic [1:0] n;
        t_result    ent0;
        t_result    ent1;
    } t_push;

endpackage

FILE: sv/sql_statement_splitter.sv
// order: a byte is labelled when the next byte is accepted and is written to the
// registered output queue on that accept; the final byte is queued on its own accept
// throughput: one byte per cycle, held off unless two of the four output queue
// entries are free; a final byte with one held byte queues two results there
// reset: synchronous, active low; clears lexer mode, held byte and the queue
module sql_statement_splitter
    import sqlss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // end_of_text
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser,   // [2:0] role
    output logic       m_axis_tlast    // final_byte
);

    typedef struct packed {
        t_role role;
        t_role mode;
        t_role pend;
    } t_cls;

    function automatic t_cls classify(t_role mode, t_role pend, logic [7:0] c,
                                      logic [7:0] la, logic has_la);
        t_cls       r;
        logic [7:0] q;
        r.role = ROLE_CODE;
        r.mode = mode;
        r.pend = ROLE_CODE;
        q      = (mode == ROLE_SINGLE) ? CH_SQ : CH_DQ;
        if (pend != ROLE_CODE) begin
            // second byte of a two-byte token
            r.role = pend;
        end else begin
            case (mode)
                ROLE_LINE: begin
                    r.role = ROLE_LINE;
                    if (c == CH_LF) r.mode = ROLE_CODE;
                end
                ROLE_BLOCK: begin
                    r.role = ROLE_BLOCK;
                    if (c == CH_STAR && has_la && la == CH_SLASH) begin
                        r.mode = ROLE_CODE;
                        r.pend = ROLE_BLOCK;
                    end
                end
                ROLE_SINGLE, ROLE_DOUBLE: begin
                    r.role = mode;
                    if (c == q && has_la && la == q) begin
                        r.pend = mode;
                    end else if (c == q) begin
                        r.mode = ROLE_CODE;
                    end
                end
                default: begin
                    r.mode = ROLE_CODE;
                    if (c == CH_DASH && has_la && la == CH_DASH) begin
                        r.mode = ROLE_LINE;
                        r.pend = ROLE_LINE;
                        r.role = ROLE_LINE;
                    end else if (c == CH_SLASH && has_la && la == CH_STAR) begin
                        r.mode = ROLE_BLOCK;
                        r.pend = ROLE_BLOCK;
                        r.role = ROLE_BLOCK;
                    end else if (c == CH_SQ) begin
                        r.mode = ROLE_SINGLE;
                        r.role = ROLE_SINGLE;
                    end else if (c == CH_DQ) begin
                        r.mode = ROLE_DOUBLE;
                        r.role = ROLE_DOUBLE;
                    end else if (c == CH_SEMI) begin
                        r.role = ROLE_SEP;
                    end
                end
            endcase
        end
        return r;
    endfunction

    t_role      r_mode, n_mode, r_pend, n_pend;
    logic [7:0] r_held, n_held;
    logic       r_held_vld, n_held_vld;

    t_cls       cls_held, cls_last;
    t_role      mode1, pend1;
    t_push      push;
    t_result    head;
    logic       room, accept;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    always_comb begin
        cls_held = classify(r_mode, r_pend, r_held, s_axis_tdata, 1'b1);
        mode1    = r_held_vld ? cls_held.mode : r_mode;
        pend1    = r_held_vld ? cls_held.pend : r_pend;
        cls_last = classify(mode1, pend1, s_axis_tdata, 8'h00, 1'b0);

        push.ent1 = '{data: s_axis_tdata, role: cls_last.role, fin: 1'b1};
        if (r_held_vld) begin
            push.ent0 = '{data: r_held, role: cls_held.role, fin: 1'b0};
        end else begin
            push.ent0 = push.ent1;
        end

        push.n     = 2'd0;
        n_mode     = r_mode;
        n_pend     = r_pend;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        if (accept) begin
            if (s_axis_tlast) begin
                push.n     = r_held_vld ? 2'd2 : 2'd1;
                n_mode     = ROLE_CODE;
                n_pend     = ROLE_CODE;
                n_held     = 8'h00;
                n_held_vld = 1'b0;
            end else begin
                push.n     = r_held_vld ? 2'd1 : 2'd0;
                n_mode     = mode1;
                n_pend     = pend1;
                n_held     = s_axis_tdata;
                n_held_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= ROLE_CODE;
            r_pend     <= ROLE_CODE;
            r_held     <= 8'h00;
            r_held_vld <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_pend     <= n_pend;
            r_held     <= n_held;
            r_held_vld <= n_held_vld;
        end
    end

    sqlss_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (head)
    );

    assign m_axis_tdata = head.data;
    assign m_axis_tuser = head.role;
    assign m_axis_tlast = head.fin;

endmodule

FILE: sv/sqlss_out_fifo.sv
module sqlss_out_fifo
    import sqlss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_result         r_mem [0:DEPTH-1];
    logic [AW-1:0]   r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    // room for a two-result transaction
    assign o_room  = (r_cnt <= CW'(DEPTH - 2));

    always_comb begin
        n_wr  = r_wr + AW'(i_push.n);
        n_rd  = r_rd + AW'(pop);
        n_cnt = r_cnt + CW'(i_push.n) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.ent0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wr + AW'(1)] <= i_push.ent1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: sv/sqlss_checker.sv
module sqlss_checker
    import sqlss_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // a stalled result transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // a waiting input transaction is offered unchanged until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
        else $error("input changed while stalled");

    // back-pressure only comes while the output queue holds results
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with nothing to deliver");

    // a separator label only ever sits on a semicolon
    a_sep_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ROLE_SEP |-> m_axis_tdata == CH_SEMI)
        else $error("separator on a byte other than semicolon");

    // the queue comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid straight after reset");

endmodule

bind sql_statement_splitter sqlss_checker u_sqlss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: verif/tb_sql_statement_splitter.sv
`timescale 1ns / 1ps

module tb_sql_statement_splitter;
    import sqlss_pkg::*;

    localparam logic [8:0] NO_LOOKAHEAD = 9'h100;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] text_byte
    logic       s_axis_tlast = 1'b0;    // end_of_text
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [2:0] m_axis_tuser;           // [2:0] role
    logic       m_axis_tlast;           // final_byte

    sql_statement_splitter uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // lexer copy kept by the testbench
    t_role      scan_mode = ROLE_CODE;
    t_role      forced_role = ROLE_CODE;  // ROLE_CODE here means nothing forced
    logic [7:0] held_ch = 8'h00;
    logic       held_ok = 1'b0;

    t_result    labelled_bytes[$];
    logic [7:0] script_q[$];
    int         errors = 0;
    int         sent_count = 0;
    bit         tx_idle = 1'b0;
    bit         rx_idle = 1'b0;
    int         rx_hold = 0;

    function automatic t_role lex_label(logic [7:0] c, logic [8:0] nx);
        t_role      r;
        logic [7:0] q;
        if (forced_role != ROLE_CODE) begin
            r = forced_role;
            forced_role = ROLE_CODE;
            return r;
        end
        case (scan_mode)
            ROLE_LINE: begin
                if (c == CH_LF)
                    scan_mode = ROLE_CODE;
                return ROLE_LINE;
            end
            ROLE_BLOCK: begin
                if (c == CH_STAR && nx == {1'b0, CH_SLASH}) begin
                    scan_mode = ROLE_CODE;
                    forced_role = ROLE_BLOCK;
                end
                return ROLE_BLOCK;
            end
            ROLE_SINGLE, ROLE_DOUBLE: begin
                q = (scan_mode == ROLE_SINGLE) ? CH_SQ : CH_DQ;
                r = scan_mode;
                // a doubled quote keeps the text open
                if (c == q && nx == {1'b0, q})
                    forced_role = r;
                else if (c == q)
                    scan_mode = ROLE_CODE;
                return r;
            end
            default: ;
        endcase
        scan_mode = ROLE_CODE;
        if (c == CH_DASH && nx == {1'b0, CH_DASH}) begin
            scan_mode = ROLE_LINE;
            forced_role = ROLE_LINE;
            return ROLE_LINE;
        end
        if (c == CH_SLASH && nx == {1'b0, CH_STAR}) begin
            scan_mode = ROLE_BLOCK;
            forced_role = ROLE_BLOCK;
            return ROLE_BLOCK;
        end
        if (c == CH_SQ) begin
            scan_mode = ROLE_SINGLE;
            return ROLE_SINGLE;
        end
        if (c == CH_DQ) begin
            scan_mode = ROLE_DOUBLE;
            return ROLE_DOUBLE;
        end
        if (c == CH_SEMI)
            return ROLE_SEP;
        return ROLE_CODE;
    endfunction

    function automatic void expect_result(logic [7:0] b, t_role r, logic fin);
        t_result e;
        e.data = b;
        e.role = r;
        e.fin  = fin;
        labelled_bytes.insert(labelled_bytes.size(), e);
    endfunction

    function automatic void label_accepted(logic [7:0] b, logic last);
        t_role r;
        if (held_ok) begin
            r = lex_label(held_ch, {1'b0, b});
            expect_result(held_ch, r, 1'b0);
        end
        if (last) begin
            r = lex_label(b, NO_LOOKAHEAD);
            expect_result(b, r, 1'b1);
            scan_mode = ROLE_CODE;
            forced_role = ROLE_CODE;
            held_ch = 8'h00;
            held_ok = 1'b0;
        end else begin
            held_ch = b;
            held_ok = 1'b1;
        end
    endfunction

    // mostly short pauses, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 99) < 25) begin
            rx_hold = idle_len() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic note_error(string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // compare every output transaction with the oldest labelled byte
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
            if (labelled_bytes.size() == 0) begin
                note_error($sformatf("unexpected output byte %02h role %0d last %0b",
                                     got.data, got.role, got.fin));
            end else begin
                want = labelled_bytes.pop_front();
                if (got.data !== want.data || got.role !== want.role ||
                    got.fin !== want.fin)
                    note_error($sformatf({"mismatch: byte %02h role %0d last %0b, ",
                                          "expected byte %02h role %0d last %0b"},
                                         got.data, got.role, got.fin,
                                         want.data, want.role, want.fin));
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        label_accepted(b, last);
        sent_count++;
        gap = (tx_idle && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (labelled_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_script();
        for (int i = 0; i < script_q.size(); i++)
            send_byte(script_q[i], i == script_q.size() - 1);
        script_q.delete();
    endtask

    function automatic void add_byte(logic [7:0] b);
        script_q.insert(script_q.size(), b);
    endfunction

    function automatic logic [7:0] filler();
        if ($urandom_range(0, 5) == 0)
            return 8'h20;
        return 8'($urandom_range(8'h61, 8'h7a));
    endfunction

    function automatic logic [7:0] noisy_byte();
        case ($urandom_range(0, 13))
            0: return CH_DASH;
            1: return CH_SLASH;
            2: return CH_STAR;
            3: return CH_SQ;
            4: return CH_DQ;
            5: return CH_SEMI;
            6: return CH_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one lexical construct with random content, closed properly
    function automatic void add_construct();
        int         n;
        logic [7:0] q;
        n = $urandom_range(0, 6);
        case ($urandom_range(0, 5))
            0: begin
                repeat (n + 1) add_byte(filler());
                add_byte(CH_SEMI);
            end
            1: begin
                add_byte(CH_DASH);
                add_byte(CH_DASH);
                repeat (n) add_byte($urandom_range(0, 1) ? filler() : CH_STAR);
                add_byte(CH_LF);
            end
            2: begin
                add_byte(CH_SLASH);
                add_byte(CH_STAR);
                repeat (n) add_byte($urandom_range(0, 2) ? filler() : CH_SQ);
                add_byte(CH_STAR);
                add_byte(CH_SLASH);
            end
            3, 4: begin
                q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
                add_byte(q);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) begin
                        add_byte(q);
                        add_byte(q);
                    end else begin
                        add_byte($urandom_range(0, 3) ? filler() : CH_SEMI);
                    end
                end
                add_byte(q);
            end
            default: add_byte($urandom_range(0, 1) ? CH_LF : 8'h20);
        endcase
    endfunction

    task automatic test_single_byte_scripts();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        wait_drained();
    endtask

    task automatic test_token_boundaries();
        // doubled quotes, comment open and close, script ending inside a comment
        send_text({"a;--\n/**/''''", "\"\"\"\"", "/*"});
        wait_drained();
    endtask

    task automatic test_wellformed_scripts(int target);
        int stop_at;
        int n;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        stop_at = sent_count + target;
        while (sent_count < stop_at) begin
            n = $urandom_range(1, 8);
            repeat (n) add_construct();
            // now and then cut a script short, leaving a construct open
            if ($urandom_range(0, 4) == 0 && script_q.size() > 1)
                script_q = script_q[0:$urandom_range(0, script_q.size() - 2)];
            send_script();
            // hold off until the output side has caught up
            if (sent_count > stop_at - target / 2 && $urandom_range(0, 9) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_random_noise(int target);
        int stop_at;
        int r;
        int n;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        stop_at = sent_count + target;
        while (sent_count < stop_at) begin
            r = $urandom_range(0, 99);
            n = (r < 10) ? 1 : (r < 90) ? $urandom_range(2, 24) : $urandom_range(25, 60);
            repeat (n) add_byte(noisy_byte());
            send_script();
        end
        wait_drained();
    endtask

    task automatic test_back_to_back(int target);
        int stop_at;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        stop_at = sent_count + target;
        while (sent_count < stop_at) begin
            repeat ($urandom_range(1, 5)) add_construct();
            if ($urandom_range(0, 2) == 0)
                add_byte(noisy_byte());
            send_script();
        end
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_byte_scripts();
        test_token_boundaries();
        test_wellformed_scripts(300);
        test_random_noise(150);
        test_back_to_back(80);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && labelled_bytes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
